// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define VTV_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// clocked assertion that also holds across reset
`define VTV_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vtv_pkg.sv =====
// shared types, codes and saturation helper for the vertex transform block
package vtv_pkg;

    localparam int FIELD_W = 32;
    localparam int ACC_W   = 68;

    typedef logic signed [FIELD_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_VIEWPORT_LEFT = 2'd0,
        REG_VIEWPORT_TOP  = 2'd1,
        REG_FB_WIDTH      = 2'd2,
        REG_FB_HEIGHT     = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        MODE_LOAD      = 1'b0,
        MODE_TRANSFORM = 1'b1
    } mode_t;

    typedef enum logic {
        SEL_WORLD     = 1'b0,
        SEL_VIEW_PROJ = 1'b1
    } mat_sel_t;

    // per-item control that travels with the data
    typedef struct packed {
        mode_t      mode;
        mat_sel_t   sel;
        logic [3:0] idx;
        coord_t     value;
        logic       fault;
    } item_ctl_t;

    // clamp a wide sum to the signed range of cwe bits
    function automatic coord_t sat_coord(acc_t v, int cwe);
        acc_t qmax;
        acc_t qmin;
        qmax = (acc_t'(1) <<< (cwe - 1)) - acc_t'(1);
        qmin = ~qmax;
        if (v > qmax) begin
            return qmax[FIELD_W-1:0];
        end else if (v < qmin) begin
            return qmin[FIELD_W-1:0];
        end
        return v[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/vertex_transform_viewport_top.sv =====
// vertex transform top level: input register, two transforms, viewport, output skid
//
//  channel   dir  handshake           contents
//  s_        in   s_tvalid/s_tready   vertex transaction or matrix element load
//  m_        out  m_tvalid/m_tready   projected point, screen x/y, w fault
//  cfg_      in   cfg_valid/cfg_ready viewport and framebuffer registers
//
//  one item per cycle while the skid register is empty; each transform ends in
//  a bit-per-stage w divider. loads flow through and give no result. reset is
//  synchronous and empties every stage; the matrices clear to zero. when
//  m_tready drops, one more result lands in the skid register and the whole
//  pipeline then holds until the skid drains.
module vertex_transform_viewport_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [135:0]      s_tdata,   // element_index, element_value, vertex_x, _y, _z
    input  logic [1:0]        s_tuser,   // mode, matrix_select
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [159:0]      m_tdata,   // ndc_x, ndc_y, ndc_z, screen_x, screen_y
    output logic [0:0]        m_tuser,   // w_fault
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  vtv_pkg::cfg_reg_t cfg_index,
    input  logic [12:0]       cfg_data
);
    import vtv_pkg::*;

    localparam int CWE = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;

    logic [11:0]  vp_left_reg;
    logic [11:0]  vp_top_reg;
    logic [12:0]  fb_width_reg;
    logic [12:0]  fb_height_reg;

    logic         en;
    logic         in_valid_reg;
    item_ctl_t    in_ctl_reg;
    coord_t       in_vec_reg [3];

    logic         w_valid;
    item_ctl_t    w_ctl;
    coord_t       w_vec [3];
    logic         p_valid;
    item_ctl_t    p_ctl;
    coord_t       p_vec [3];
    logic         v_valid;
    item_ctl_t    v_ctl;
    coord_t       v_vec [3];
    coord_t       v_sx;
    coord_t       v_sy;

    logic         res_valid;
    logic [160:0] res_data;
    logic         out_free;
    logic         out_valid_reg;
    logic [160:0] out_data_reg;
    logic         skid_valid_reg;
    logic [160:0] skid_data_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_left_reg   <= 12'd0;
            vp_top_reg    <= 12'd0;
            fb_width_reg  <= 13'd640;
            fb_height_reg <= 13'd480;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_VIEWPORT_LEFT: vp_left_reg   <= cfg_data[11:0];
                REG_VIEWPORT_TOP:  vp_top_reg    <= cfg_data[11:0];
                REG_FB_WIDTH:      fb_width_reg  <= cfg_data;
                REG_FB_HEIGHT:     fb_height_reg <= cfg_data;
            endcase
        end
    end

    // pipeline advances unless the skid register is occupied
    assign en       = !skid_valid_reg;
    assign s_tready = aresetn && en;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_ctl_reg.mode  <= mode_t'(s_tuser[0]);
            in_ctl_reg.sel   <= mat_sel_t'(s_tuser[1]);
            in_ctl_reg.idx   <= s_tdata[3:0];
            in_ctl_reg.value <= s_tdata[35:4];
            in_ctl_reg.fault <= 1'b0;
            in_vec_reg[0]    <= s_tdata[67:36];
            in_vec_reg[1]    <= s_tdata[99:68];
            in_vec_reg[2]    <= s_tdata[131:100];
        end
    end

    // world transform
    vtv_xform #(
        .SEL (SEL_WORLD),
        .CWE (CWE),
        .FB  (FRAC_BITS)
    ) u_world (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_ctl    (in_ctl_reg),
        .in_vec    (in_vec_reg),
        .out_valid (w_valid),
        .out_ctl   (w_ctl),
        .out_vec   (w_vec)
    );

    // camera-projection transform
    vtv_xform #(
        .SEL (SEL_VIEW_PROJ),
        .CWE (CWE),
        .FB  (FRAC_BITS)
    ) u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (w_valid),
        .in_ctl    (w_ctl),
        .in_vec    (w_vec),
        .out_valid (p_valid),
        .out_ctl   (p_ctl),
        .out_vec   (p_vec)
    );

    // viewport mapping
    vtv_view #(
        .CWE (CWE),
        .FB  (FRAC_BITS)
    ) u_view (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vp_left   (vp_left_reg),
        .vp_top    (vp_top_reg),
        .fb_width  (fb_width_reg),
        .fb_height (fb_height_reg),
        .in_valid  (p_valid),
        .in_ctl    (p_ctl),
        .in_vec    (p_vec),
        .out_valid (v_valid),
        .out_ctl   (v_ctl),
        .out_vec   (v_vec),
        .out_sx    (v_sx),
        .out_sy    (v_sy)
    );

    // only transform transactions leave as results
    assign res_valid = en && v_valid && (v_ctl.mode == MODE_TRANSFORM);
    assign res_data  = {v_ctl.fault, v_sy, v_sx, v_vec[2], v_vec[1], v_vec[0]};
    assign out_free  = !out_valid_reg || m_tready;

    // output register and skid control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end else if (res_valid) begin
            skid_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg[159:0];
    assign m_tuser  = out_data_reg[160:160];

endmodule

// ===== rtl/vtv_div.sv =====
// pipelined restoring divider: three numerators over one shared w, one bit per stage
module vtv_div #(
    parameter int CWE = 32,
    parameter int FB  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  vtv_pkg::item_ctl_t  in_ctl,
    input  vtv_pkg::coord_t     in_num [3],
    input  vtv_pkg::coord_t     in_den,
    output logic                out_valid,
    output vtv_pkg::item_ctl_t  out_ctl,
    output vtv_pkg::coord_t     out_q [3]
);
    import vtv_pkg::*;

    localparam int NB    = FIELD_W + FB;
    localparam int NB_P1 = NB + 1;
    localparam logic [NB:0] QMAX_U = NB_P1'((64'd1 << (CWE - 1)) - 64'd1);
    localparam coord_t Q_MAX = coord_t'((64'sd1 <<< (CWE - 1)) - 64'sd1);
    localparam coord_t Q_MIN = ~Q_MAX;

    typedef struct packed {
        logic [2:0] c_neg;
        logic [2:0] c_nz;
        logic       w_neg;
        logic       w_zero;
    } div_flags_t;

    logic [NB:0]        vld_reg;
    logic [NB-1:0]      nq_reg   [NB+1][3];
    logic [FIELD_W-1:0] rem_reg  [NB+1][3];
    logic [FIELD_W-1:0] d_reg    [NB+1];
    div_flags_t         flg_reg  [NB+1];
    item_ctl_t          ctl_reg  [NB+1];

    logic [FIELD_W-1:0] mag_c [3];
    logic [FIELD_W-1:0] mag_w;
    logic [FIELD_W:0]   trial [NB][3];
    logic [FIELD_W:0]   diff  [NB][3];
    logic               ge    [NB][3];

    // magnitudes for the setup stage
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            mag_c[l] = in_num[l][FIELD_W-1] ? (~in_num[l] + 1'b1) : in_num[l];
        end
        mag_w = in_den[FIELD_W-1] ? (~in_den + 1'b1) : in_den;
    end

    // trial subtraction of every stage
    always_comb begin
        for (int k = 0; k < NB; k++) begin
            for (int l = 0; l < 3; l++) begin
                trial[k][l] = {rem_reg[k][l], nq_reg[k][l][NB-1]};
                diff[k][l]  = trial[k][l] - {1'b0, d_reg[k]};
                ge[k][l]    = trial[k][l] >= {1'b0, d_reg[k]};
            end
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            out_valid <= 1'b0;
        end else if (en) begin
            vld_reg   <= {vld_reg[NB-1:0], in_valid};
            out_valid <= vld_reg[NB];
        end
    end

    // setup and iteration stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                nq_reg[0][l]  <= {mag_c[l], {FB{1'b0}}};
                rem_reg[0][l] <= '0;
                flg_reg[0].c_neg[l] <= in_num[l][FIELD_W-1];
                flg_reg[0].c_nz[l]  <= |in_num[l];
            end
            flg_reg[0].w_neg  <= in_den[FIELD_W-1];
            flg_reg[0].w_zero <= ~|in_den;
            d_reg[0]   <= mag_w;
            ctl_reg[0] <= in_ctl;
            for (int k = 0; k < NB; k++) begin
                for (int l = 0; l < 3; l++) begin
                    rem_reg[k+1][l] <= ge[k][l] ? diff[k][l][FIELD_W-1:0]
                                                : trial[k][l][FIELD_W-1:0];
                    nq_reg[k+1][l]  <= {nq_reg[k][l][NB-2:0], ge[k][l]};
                end
                d_reg[k+1]   <= d_reg[k];
                flg_reg[k+1] <= flg_reg[k];
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    // sign, saturation and zero-w handling
    always_ff @(posedge aclk) begin
        if (en) begin
            out_ctl.mode  <= ctl_reg[NB].mode;
            out_ctl.sel   <= ctl_reg[NB].sel;
            out_ctl.idx   <= ctl_reg[NB].idx;
            out_ctl.value <= ctl_reg[NB].value;
            out_ctl.fault <= ctl_reg[NB].fault | flg_reg[NB].w_zero;
            for (int l = 0; l < 3; l++) begin
                if (flg_reg[NB].w_zero) begin
                    out_q[l] <= !flg_reg[NB].c_nz[l] ? '0 :
                                (flg_reg[NB].c_neg[l] ? Q_MIN : Q_MAX);
                end else if (flg_reg[NB].c_neg[l] ^ flg_reg[NB].w_neg) begin
                    out_q[l] <= ({1'b0, nq_reg[NB][l]} > QMAX_U + 1'b1) ? Q_MIN
                              : coord_t'(~nq_reg[NB][l][FIELD_W-1:0] + 1'b1);
                end else begin
                    out_q[l] <= ({1'b0, nq_reg[NB][l]} > QMAX_U) ? Q_MAX
                              : coord_t'(nq_reg[NB][l][FIELD_W-1:0]);
                end
            end
        end
    end

endmodule

// ===== rtl/vtv_xform.sv =====
// one matrix transform: element store, product stage, sum stage and w divide
module vtv_xform #(
    parameter vtv_pkg::mat_sel_t SEL = vtv_pkg::SEL_WORLD,
    parameter int                CWE = 32,
    parameter int                FB  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  vtv_pkg::item_ctl_t  in_ctl,
    input  vtv_pkg::coord_t     in_vec [3],
    output logic                out_valid,
    output vtv_pkg::item_ctl_t  out_ctl,
    output vtv_pkg::coord_t     out_vec [3]
);
    import vtv_pkg::*;

    localparam int PROD_W = 2 * FIELD_W;

    coord_t                    mat_reg  [16];
    logic signed [PROD_W-1:0]  prod_reg [4][3];
    coord_t                    bias_reg [4];
    item_ctl_t                 ctl1_reg;
    logic                      valid1_reg;
    acc_t                      sum_next [4];
    coord_t                    h_reg    [4];
    item_ctl_t                 ctl2_reg;
    logic                      valid2_reg;
    logic                      load_hit;

    assign load_hit = in_valid && (in_ctl.mode == MODE_LOAD) && (in_ctl.sel == SEL);

    // matrix element store, written in item order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= '0;
            end
        end else if (en && load_hit) begin
            mat_reg[in_ctl.idx] <= in_ctl.value;
        end
    end

    // valid bits of the product and sum stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    // element times coordinate products
    always_ff @(posedge aclk) begin
        if (en) begin
            ctl1_reg <= in_ctl;
            for (int c = 0; c < 4; c++) begin
                bias_reg[c] <= mat_reg[12+c];
                for (int r = 0; r < 3; r++) begin
                    prod_reg[c][r] <= mat_reg[r*4+c] * in_vec[r];
                end
            end
        end
    end

    // floor to fraction bits and column sums
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum_next[c] = acc_t'(bias_reg[c])
                        + acc_t'(prod_reg[c][0] >>> FB)
                        + acc_t'(prod_reg[c][1] >>> FB)
                        + acc_t'(prod_reg[c][2] >>> FB);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl2_reg <= ctl1_reg;
            for (int c = 0; c < 4; c++) begin
                h_reg[c] <= sat_coord(sum_next[c], CWE);
            end
        end
    end

    // perspective divide by the fourth column
    vtv_div #(
        .CWE (CWE),
        .FB  (FB)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid2_reg),
        .in_ctl    (ctl2_reg),
        .in_num    (h_reg[0:2]),
        .in_den    (h_reg[3]),
        .out_valid (out_valid),
        .out_ctl   (out_ctl),
        .out_q     (out_vec)
    );

endmodule

// ===== rtl/vtv_view.sv =====
// viewport mapping: size products, then halving, offset and saturation
module vtv_view #(
    parameter int CWE = 32,
    parameter int FB  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [11:0]         vp_left,
    input  logic [11:0]         vp_top,
    input  logic [12:0]         fb_width,
    input  logic [12:0]         fb_height,
    input  logic                in_valid,
    input  vtv_pkg::item_ctl_t  in_ctl,
    input  vtv_pkg::coord_t     in_vec [3],
    output logic                out_valid,
    output vtv_pkg::item_ctl_t  out_ctl,
    output vtv_pkg::coord_t     out_vec [3],
    output vtv_pkg::coord_t     out_sx,
    output vtv_pkg::coord_t     out_sy
);
    import vtv_pkg::*;

    localparam int PX_W = FIELD_W + 14;

    logic signed [PX_W-1:0] px_reg;
    logic signed [PX_W-1:0] py_reg;
    coord_t                 n_reg [3];
    item_ctl_t              ctl1_reg;
    logic                   valid1_reg;
    acc_t                   sx_sum;
    acc_t                   sy_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            out_valid  <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            out_valid  <= valid1_reg;
        end
    end

    // scale by framebuffer size
    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= in_vec[0] * $signed({1'b0, fb_width});
            py_reg   <= in_vec[1] * $signed({1'b0, fb_height});
            n_reg    <= in_vec;
            ctl1_reg <= in_ctl;
        end
    end

    // half, center and offset
    always_comb begin
        sx_sum = (acc_t'(vp_left) <<< FB)
               + ((acc_t'(px_reg) + (acc_t'(fb_width) <<< FB)) >>> 1);
        sy_sum = (acc_t'(vp_top) <<< FB)
               + (((acc_t'(fb_height) <<< FB) - acc_t'(py_reg)) >>> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_sx  <= sat_coord(sx_sum, CWE);
            out_sy  <= sat_coord(sy_sum, CWE);
            out_vec <= n_reg;
            out_ctl <= ctl1_reg;
        end
    end

endmodule

// ===== rtl/vtv_checker.sv =====
// port-level checks of the vertex transform top level, bound to it
`include "assert_macros.svh"

module vtv_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // a stalled result holds
    `VTV_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // input stalls only after output backpressure
    `VTV_ASSERT(a_ready_cause, aclk, aresetn, !s_tready |-> $past(m_tvalid && !m_tready), "input stalled without backpressure")

    // a held-off input means a result is waiting
    `VTV_ASSERT(a_ready_out, aclk, aresetn, !s_tready |-> m_tvalid, "input stalled with no result pending")

    // reset empties the output
    `VTV_ASSERT_NORST(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind vertex_transform_viewport_top vtv_checker u_vtv_checker (.*);

// ===== verif/tb.sv =====
// self-checking testbench for the vertex transform and viewport block
module tb;
    import vtv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC       = 16;
    localparam int  DRAIN_WAIT = 130;
    localparam int  LIMIT      = 600000;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    cfg_reg_t     cfg_index;
    logic [12:0]  cfg_data;

    // one expected result
    typedef struct {
        logic [31:0] ndc_x;
        logic [31:0] ndc_y;
        logic [31:0] ndc_z;
        logic [31:0] scr_x;
        logic [31:0] scr_y;
        logic        fault;
    } point_t;

    point_t pending_points[$];

    // shadow of the matrices and the viewport registers
    logic signed [31:0] mat_shadow [2][16];
    longint vp_left, vp_top, fb_w, fb_h;

    int errors;
    int n_xforms, n_loads, n_faults, n_checked;
    int burst_left;
    longint cycles = 0;

    vertex_transform_viewport_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // receiver stall pattern, cycling through four characters
    always @(negedge aclk) begin
        case ((cycles / 300) % 4)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= ($urandom_range(0, 9) != 0);
            end
            default: begin
                m_tready <= ((cycles % 16) < 11);
            end
        endcase
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // row vector (x, y, z, 1) times one stored matrix, then divide by w
    task automatic apply_matrix(input int sel, input longint vin [3], output longint vout [3],
                                inout bit fault);
        longint h [4];
        longint acc;
        for (int c = 0; c < 4; c++) begin
            acc = longint'(mat_shadow[sel][12 + c]);
            for (int r = 0; r < 3; r++) begin
                acc += (longint'(mat_shadow[sel][r * 4 + c]) * vin[r]) >>> FRAC;
            end
            h[c] = sat32(acc);
        end
        for (int c = 0; c < 3; c++) begin
            if (h[3] == 0) begin
                fault = 1'b1;
                vout[c] = (h[c] > 0) ? 64'sd2147483647 :
                          (h[c] < 0) ? -64'sd2147483648 : 64'sd0;
            end else begin
                vout[c] = sat32((h[c] <<< FRAC) / h[3]);
            end
        end
    endtask

    // expected point for one vertex
    task automatic project_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                                  input logic signed [31:0] z);
        longint v [3];
        longint a [3];
        longint n [3];
        bit     fault;
        point_t p;
        fault = 1'b0;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        apply_matrix(SEL_WORLD, v, a, fault);
        apply_matrix(SEL_VIEW_PROJ, a, n, fault);
        p.ndc_x = n[0][31:0];
        p.ndc_y = n[1][31:0];
        p.ndc_z = n[2][31:0];
        p.scr_x = 32'(sat32((vp_left <<< FRAC) + ((n[0] * fb_w + (fb_w <<< FRAC)) >>> 1)));
        p.scr_y = 32'(sat32((vp_top <<< FRAC) + (((fb_h <<< FRAC) - n[1] * fb_h) >>> 1)));
        p.fault = fault;
        pending_points.push_back(p);
    endtask

    // send one input transaction, with bursty gaps afterwards
    task automatic send_item(input mode_t mode, input mat_sel_t sel, input logic [3:0] idx,
                             input logic signed [31:0] val, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, mode};
        s_tdata  <= {4'b0, z, y, x, val, idx};
        do @(posedge aclk); while (!s_tready);
        if (mode == MODE_LOAD) begin
            mat_shadow[sel][idx] = val;
            n_loads++;
        end else begin
            project_vertex(x, y, z);
            n_xforms++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic load_elem(input mat_sel_t sel, input logic [3:0] idx,
                             input logic signed [31:0] val);
        send_item(MODE_LOAD, sel, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic xform(input logic signed [31:0] x, input logic signed [31:0] y,
                         input logic signed [31:0] z);
        send_item(MODE_TRANSFORM, mat_sel_t'($urandom_range(0, 1)), 4'($urandom), $urandom,
                  x, y, z);
    endtask

    // wait for every expected point and let loads in flight settle
    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [12:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_VIEWPORT_LEFT: vp_left = val[11:0];
            REG_VIEWPORT_TOP:  vp_top  = val[11:0];
            REG_FB_WIDTH:      fb_w    = val;
            default:           fb_h    = val;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_viewport(input logic [12:0] l, input logic [12:0] t,
                                input logic [12:0] w, input logic [12:0] h);
        write_reg(REG_VIEWPORT_LEFT, l);
        write_reg(REG_VIEWPORT_TOP, t);
        write_reg(REG_FB_WIDTH, w);
        write_reg(REG_FB_HEIGHT, h);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %08h expected %08h (result %0d)", what, got, want, n_checked);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        point_t p;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                report("unexpected transaction", m_tdata[31:0], 32'h0);
            end else begin
                p = pending_points.pop_front();
                if (m_tdata[31:0]    !== p.ndc_x) report("ndc_x", m_tdata[31:0], p.ndc_x);
                if (m_tdata[63:32]   !== p.ndc_y) report("ndc_y", m_tdata[63:32], p.ndc_y);
                if (m_tdata[95:64]   !== p.ndc_z) report("ndc_z", m_tdata[95:64], p.ndc_z);
                if (m_tdata[127:96]  !== p.scr_x) report("screen_x", m_tdata[127:96], p.scr_x);
                if (m_tdata[159:128] !== p.scr_y) report("screen_y", m_tdata[159:128], p.scr_y);
                if (m_tuser[0] !== p.fault) report("w_fault", {31'b0, m_tuser[0]}, {31'b0, p.fault});
                if (p.fault) n_faults++;
            end
            n_checked++;
        end
    end

    // zero matrices after reset: w is zero, everything collapses to the center
    task automatic test_reset_state;
        xform(32'sh0001_0000, -32'sh0002_0000, 32'sh0);
        xform(32'sh0, 32'sh0, 32'sh0);
    endtask

    // identity matrices, extreme vertex coordinates, zero w with signed numerators
    task automatic test_directed_points;
        for (int i = 0; i < 4; i++) begin
            load_elem(SEL_WORLD, 4'(i * 5), Q_ONE);
            load_elem(SEL_VIEW_PROJ, 4'(i * 5), Q_ONE);
        end
        xform(32'sh0000_8000, -32'sh0000_4000, 32'sh0000_2000);
        xform(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        xform(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        // world row 0 column 3 = -1 makes w zero at x = 1
        load_elem(SEL_WORLD, 4'd3, -Q_ONE);
        xform(Q_ONE, Q_ONE, -Q_ONE);
        xform(Q_ONE, 32'sh0, 32'sh0);
        // extreme element values
        load_elem(SEL_WORLD, 4'd3, 32'sh0);
        load_elem(SEL_VIEW_PROJ, 4'd0, 32'sh7FFF_FFFF);
        load_elem(SEL_VIEW_PROJ, 4'd6, 32'sh8000_0000);
        xform(Q_ONE, -Q_ONE, Q_ONE);
        drain();
    endtask

    // viewport registers at their extremes and beyond the usual range
    task automatic test_viewport_extremes;
        logic [12:0] cfgs [4][4];
        cfgs = '{'{13'd4095, 13'd4095, 13'd1, 13'd1},
                 '{13'd0, 13'd0, 13'd4096, 13'd4096},
                 '{13'd4095, 13'd0, 13'd0, 13'd8191},
                 '{13'd0, 13'd4095, 13'd8191, 13'd0}};
        for (int k = 0; k < 4; k++) begin
            set_viewport(cfgs[k][0], cfgs[k][1], cfgs[k][2], cfgs[k][3]);
            xform(Q_ONE, -Q_ONE, 32'sh0);
            xform(-32'sh0000_8000, 32'sh0000_8000, Q_ONE);
            xform(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
            drain();
        end
    endtask

    function automatic logic signed [31:0] modest_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'sh0;
        if (r == 1) return $urandom;
        return int'($urandom_range(0, 524288)) - 262144;
    endfunction

    // random matrices and vertices, mostly well scaled, some raw noise
    task automatic test_random_stream;
        int r;
        for (int ph = 0; ph < 5; ph++) begin
            set_viewport(13'($urandom_range(0, 4095)), 13'($urandom_range(0, 4095)),
                         13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
            for (int e = 0; e < 32; e++) begin
                load_elem(mat_sel_t'(e / 16), 4'(e), modest_value());
            end
            for (int i = 0; i < 200; i++) begin
                r = $urandom_range(0, 19);
                if (r < 14) begin
                    xform(int'($urandom_range(0, 33554432)) - 16777216,
                          int'($urandom_range(0, 33554432)) - 16777216,
                          int'($urandom_range(0, 33554432)) - 16777216);
                end else if (r < 18) begin
                    load_elem(mat_sel_t'($urandom_range(0, 1)), 4'($urandom), modest_value());
                end else begin
                    send_item(mode_t'($urandom_range(0, 1)), mat_sel_t'($urandom_range(0, 1)),
                              4'($urandom), $urandom, $urandom, $urandom, $urandom);
                end
            end
            // hold the sender until all results are back
            drain();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_VIEWPORT_LEFT;
        cfg_data  = '0;
        errors    = 0;
        n_xforms  = 0;
        n_loads   = 0;
        n_faults  = 0;
        n_checked = 0;
        burst_left = 0;
        vp_left = 0;
        vp_top  = 0;
        fb_w    = 640;
        fb_h    = 480;
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < 16; i++) mat_shadow[s][i] = '0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_directed_points();
        test_viewport_extremes();
        test_random_stream();
        drain();

        $display("covered %0d vertex transactions and %0d matrix loads, %0d with a zero w",
                 n_xforms, n_loads, n_faults);
        $display("viewport settings included zero, minimum and maximum sizes and offsets");
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
